// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

// ----- sv/rftp_pkg.sv -----
// Package: types, character codes and limits for the replay frame text parser.
package rftp_pkg;

   localparam logic [7:0] CharComma = 8'h2C;
   localparam logic [7:0] CharBar   = 8'h7C;
   localparam logic [7:0] CharPlus  = 8'h2B;
   localparam logic [7:0] CharMinus = 8'h2D;
   localparam logic [7:0] CharDot   = 8'h2E;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharTab   = 8'h09;
   localparam logic [7:0] CharCr    = 8'h0D;

   localparam int unsigned TimeWidth  = 64;
   localparam int unsigned FrameTimeWidth = 63;
   localparam int unsigned KeyWidth   = 32;

   localparam logic [63:0] DeltaCap    = 64'h8000_0000_0000_0000;
   localparam logic [63:0] DeltaMax    = 64'h7FFF_FFFF_FFFF_FFFF;
   // floor(DeltaCap / 10): a digit of 9 overflows one step earlier
   localparam logic [63:0] DeltaLimit  = 64'd922337203685477580;
   localparam logic [31:0] KeyCap      = 32'h8000_0000;
   localparam logic [31:0] KeyMax      = 32'h7FFF_FFFF;
   localparam logic [31:0] KeyLimit    = 32'd214748364;
   localparam logic [63:0] EndMarker   = 64'd12345;
   localparam logic [3:0]  DigitNine   = 4'd9;

   localparam logic [1:0] BarsNone = 2'd0;
   localparam logic [1:0] BarsOne  = 2'd1;
   localparam logic [1:0] BarsTwo  = 2'd2;

   typedef struct packed {
      logic [63:0] addend;
      logic        carry;
      logic        has_digit;
      logic        is_zero;
      logic        is_marker;
   } delta_info_type;

   typedef struct packed {
      logic [31:0] key_bits;
      logic        has_digit;
   } key_info_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CharZero) && (c <= CharNine);
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
   endfunction

   function automatic logic is_sign(input logic [7:0] c);
      return (c == CharPlus) || (c == CharMinus);
   endfunction

endpackage

// ----- sv/rftp_req_if.sv -----
// Interface: request channel carrying one text byte per word.
interface rftp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ----- sv/rftp_rsp_if.sv -----
// Interface: response channel carrying one parsed frame per word.
interface rftp_rsp_if;
   logic               valid;
   logic               ready;
   logic [62:0]        frame_time;
   logic signed [31:0] key_state;

   modport source (output valid, output frame_time, output key_state, input ready);
   modport sink (input valid, input frame_time, input key_state, output ready);
endinterface

// ----- sv/rftp_delta_field.sv -----
// Delta field parser: signed decimal accumulator with saturation.
module rftp_delta_field
   import rftp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           feed,
   input  logic           clear,
   input  logic [7:0]     text_byte,
   output delta_info_type info
);

   logic [63:0] value_ff, value_in;
   logic        negative_ff, negative_in;
   logic        has_digit_ff, has_digit_in;
   logic        closed_ff, closed_in;
   logic        signed_ff, signed_in;
   logic [3:0]  digit;
   logic        overflow;
   logic [63:0] pushed;

   assign digit    = text_byte[3:0];
   assign overflow = (value_ff > DeltaLimit) || ((value_ff == DeltaLimit) && (digit == DigitNine));
   assign pushed   = overflow ? DeltaCap
                              : (value_ff << 3) + (value_ff << 1) + {60'd0, digit};

   always_comb begin
      value_in     = value_ff;
      negative_in  = negative_ff;
      has_digit_in = has_digit_ff;
      closed_in    = closed_ff;
      signed_in    = signed_ff;
      if (clear) begin
         value_in     = '0;
         negative_in  = 1'b0;
         has_digit_in = 1'b0;
         closed_in    = 1'b0;
         signed_in    = 1'b0;
      end else if (feed && !closed_ff) begin
         priority if (is_digit(text_byte)) begin
            has_digit_in = 1'b1;
            value_in     = pushed;
         end else if (!has_digit_ff && !signed_ff && is_blank(text_byte)) begin
            // skip leading blank
         end else if (!has_digit_ff && !signed_ff && is_sign(text_byte)) begin
            signed_in   = 1'b1;
            negative_in = (text_byte == CharMinus);
         end else begin
            closed_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff     <= '0;
         negative_ff  <= 1'b0;
         has_digit_ff <= 1'b0;
         closed_ff    <= 1'b0;
         signed_ff    <= 1'b0;
      end else begin
         value_ff     <= value_in;
         negative_ff  <= negative_in;
         has_digit_ff <= has_digit_in;
         closed_ff    <= closed_in;
         signed_ff    <= signed_in;
      end
   end

   // negative: add ~value + 1; positive: clamp to the signed range
   always_comb begin
      info.addend    = negative_ff ? ~value_ff
                                   : ((value_ff >= DeltaCap) ? DeltaMax : value_ff);
      info.carry     = negative_ff;
      info.has_digit = has_digit_ff;
      info.is_zero   = (value_ff == '0);
      info.is_marker = negative_ff && (value_ff == EndMarker);
   end

endmodule

// ----- sv/rftp_key_field.sv -----
// Key field parser: signed decimal with fraction cut off, saturated to 32 bits.
module rftp_key_field
   import rftp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         feed,
   input  logic         clear,
   input  logic [7:0]   text_byte,
   output key_info_type info
);

   logic [31:0] value_ff, value_in;
   logic        negative_ff, negative_in;
   logic        has_digit_ff, has_digit_in;
   logic        closed_ff, closed_in;
   logic        signed_ff, signed_in;
   logic        fraction_ff, fraction_in;
   logic [3:0]  digit;
   logic        overflow;
   logic [31:0] pushed;

   assign digit    = text_byte[3:0];
   assign overflow = (value_ff > KeyLimit) || ((value_ff == KeyLimit) && (digit == DigitNine));
   assign pushed   = overflow ? KeyCap
                              : (value_ff << 3) + (value_ff << 1) + {28'd0, digit};

   always_comb begin
      value_in     = value_ff;
      negative_in  = negative_ff;
      has_digit_in = has_digit_ff;
      closed_in    = closed_ff;
      signed_in    = signed_ff;
      fraction_in  = fraction_ff;
      if (clear) begin
         value_in     = '0;
         negative_in  = 1'b0;
         has_digit_in = 1'b0;
         closed_in    = 1'b0;
         signed_in    = 1'b0;
         fraction_in  = 1'b0;
      end else if (feed && !closed_ff) begin
         priority if (is_digit(text_byte)) begin
            has_digit_in = 1'b1;
            if (!fraction_ff) begin
               value_in = pushed;
            end
         end else if (fraction_ff) begin
            closed_in = 1'b1;
         end else if (text_byte == CharDot) begin
            fraction_in = 1'b1;
            signed_in   = 1'b1;
         end else if (!has_digit_ff && !signed_ff && is_blank(text_byte)) begin
            // skip leading blank
         end else if (!has_digit_ff && !signed_ff && is_sign(text_byte)) begin
            signed_in   = 1'b1;
            negative_in = (text_byte == CharMinus);
         end else begin
            closed_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff     <= '0;
         negative_ff  <= 1'b0;
         has_digit_ff <= 1'b0;
         closed_ff    <= 1'b0;
         signed_ff    <= 1'b0;
         fraction_ff  <= 1'b0;
      end else begin
         value_ff     <= value_in;
         negative_ff  <= negative_in;
         has_digit_ff <= has_digit_in;
         closed_ff    <= closed_in;
         signed_ff    <= signed_in;
         fraction_ff  <= fraction_in;
      end
   end

   always_comb begin
      info.key_bits  = negative_ff ? (32'd0 - value_ff)
                                   : ((value_ff >= KeyCap) ? KeyMax : value_ff);
      info.has_digit = has_digit_ff;
   end

endmodule

// ----- sv/replay_frame_text_parser.sv -----
// Top level: replay frame text parser with input register and result register.
//
//   channel | dir | word contents                     | accepted when
//   req     | in  | text_byte[7:0], end_of_text       | req.valid && req.ready
//   rsp     | out | frame_time[62:0], key_state[31:0] | rsp.valid && rsp.ready
//
// One byte per cycle sustained unless a frame is held by a stalled rsp; a byte goes
// from the input register into the result register. The per-byte path is the 64-bit
// multiply-by-ten accumulate and the running-time adder. A byte that yields no frame
// advances even while rsp is stalled. Synchronous reset restores all control state;
// end_of_text restores frame state and the field parsers after its byte.
`include "assert_macros.svh"
module replay_frame_text_parser
   import rftp_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   rftp_req_if.sink   req,
   rftp_rsp_if.source rsp
);

   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte_ff, s1_byte_in;
   logic        s1_last_ff, s1_last_in;

   logic [63:0] elapsed_ff, elapsed_in;
   logic        awaiting_ff, awaiting_in;
   logic [1:0]  bar_ff, bar_in;
   logic        nonempty_ff, nonempty_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [62:0] rsp_time_ff, rsp_time_in;
   logic [31:0] rsp_key_ff, rsp_key_in;

   delta_info_type delta_info;
   key_info_type   key_info;

   logic        is_comma, is_bar, finish, advance;
   logic [1:0]  bar_next, fin_bar;
   logic        fin_nonempty, frame_ok, take, drop_first, emit;
   logic [63:0] sum;
   logic        delta_feed, key_feed, field_clear;
   logic        restart_state;

   assign is_comma = (s1_byte_ff == CharComma);
   assign is_bar   = (s1_byte_ff == CharBar);
   assign finish   = is_comma || s1_last_ff;
   assign bar_next = (is_bar && (bar_ff != BarsTwo)) ? bar_ff + 2'd1 : bar_ff;

   // a comma closes the frame as it stood; end_of_text closes it after the byte
   assign fin_bar      = is_comma ? bar_ff : bar_next;
   assign fin_nonempty = is_comma ? nonempty_ff : 1'b1;
   assign frame_ok     = fin_nonempty && (fin_bar == BarsTwo)
                         && delta_info.has_digit && key_info.has_digit;
   assign take         = finish && frame_ok && !delta_info.is_marker;
   assign drop_first   = awaiting_ff && delta_info.is_zero;
   assign sum          = elapsed_ff + delta_info.addend + {63'd0, delta_info.carry};
   assign emit         = s1_valid_ff && take && !drop_first && !sum[63];

   assign advance   = s1_valid_ff && (!emit || !rsp_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || advance;

   assign delta_feed  = advance && !is_comma && !is_bar && (bar_ff == BarsNone);
   assign key_feed    = advance && !is_comma && !is_bar && (bar_ff == BarsOne);
   assign field_clear = advance && finish;

   assign restart_state = (elapsed_ff == '0) && awaiting_ff && (bar_ff == BarsNone);

   rftp_delta_field u_delta (
      .clock     (clock),
      .reset     (reset),
      .feed      (delta_feed),
      .clear     (field_clear),
      .text_byte (s1_byte_ff),
      .info      (delta_info)
   );

   rftp_key_field u_key (
      .clock     (clock),
      .reset     (reset),
      .feed      (key_feed),
      .clear     (field_clear),
      .text_byte (s1_byte_ff),
      .info      (key_info)
   );

   // input register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      s1_last_in  = s1_last_ff;
      if (req.ready) begin
         s1_valid_in = req.valid;
         s1_byte_in  = req.text_byte;
         s1_last_in  = req.end_of_text;
      end
   end

   // frame state
   always_comb begin
      elapsed_in  = elapsed_ff;
      awaiting_in = awaiting_ff;
      bar_in      = bar_ff;
      nonempty_in = nonempty_ff;
      if (advance) begin
         if (take) begin
            awaiting_in = 1'b0;
            if (!drop_first) begin
               elapsed_in = sum;
            end
         end
         if (finish) begin
            bar_in      = BarsNone;
            nonempty_in = 1'b0;
         end else begin
            bar_in      = bar_next;
            nonempty_in = 1'b1;
         end
         if (s1_last_ff) begin
            elapsed_in  = '0;
            awaiting_in = 1'b1;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_time_in  = rsp_time_ff;
      rsp_key_in   = rsp_key_ff;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
         rsp_time_in  = sum[62:0];
         rsp_key_in   = key_info.key_bits;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         elapsed_ff   <= '0;
         awaiting_ff  <= 1'b1;
         bar_ff       <= BarsNone;
         nonempty_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         elapsed_ff   <= elapsed_in;
         awaiting_ff  <= awaiting_in;
         bar_ff       <= bar_in;
         nonempty_ff  <= nonempty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff  <= s1_byte_in;
      s1_last_ff  <= s1_last_in;
      rsp_time_ff <= rsp_time_in;
      rsp_key_ff  <= rsp_key_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.frame_time = rsp_time_ff;
   assign rsp.key_state  = rsp_key_ff;

   `ASSERT_ALWAYS(a_bar_range, bar_ff != 2'd3, "bar count out of range")
   `ASSERT_ALWAYS(a_stall_only_when_held, req.ready || s1_valid_ff, "ready low with empty stage")
   `ASSERT_NEXT(a_last_restarts, advance && s1_last_ff, restart_state, "no restart after end")
   `ASSERT_NEXT(a_emit_loads, advance && emit, rsp_valid_ff, "emitted frame not loaded")

endmodule
